// ----- sv/rnp_pkg.sv -----
// shared types, constants and digit decode for the radix number parser
package rnp_pkg;

   // character and result widths
   localparam int CHAR_W    = 8;
   localparam int VALUE_W   = 32;
   localparam int RADIX_W   = 2;
   localparam int DIGIT_W   = 4;
   localparam int RSP_W     = 40;
   localparam int POS_W     = 2;

   // default digit limit before the overflow flag
   localparam int MAX_DIGITS_DEF = 32;

   // characters with a special meaning
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LX    = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_LH    = 8'h68;
   localparam logic [CHAR_W-1:0] CHAR_UH    = 8'h48;
   localparam logic [CHAR_W-1:0] CHAR_LO    = 8'h6f;
   localparam logic [CHAR_W-1:0] CHAR_UO    = 8'h4f;

   // radix codes as reported on the result
   typedef enum logic [RADIX_W-1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2
   } radix_type;

   // decoded character
   typedef struct packed {
      logic               is_digit;
      logic               is_letter;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   // digit decode: 0-9, a-f, A-F
   function automatic digit_type decode_digit(input logic [CHAR_W-1:0] ch);
      digit_type d;
      logic [CHAR_W-1:0] diff;
      d = '0;
      diff = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         diff = ch - CHAR_ZERO;
         d.is_digit = 1'b1;
         d.value = diff[DIGIT_W-1:0];
      end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
         diff = ch - CHAR_LA + 8'd10;
         d.is_digit = 1'b1;
         d.is_letter = 1'b1;
         d.value = diff[DIGIT_W-1:0];
      end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
         diff = ch - CHAR_UA + 8'd10;
         d.is_digit = 1'b1;
         d.is_letter = 1'b1;
         d.value = diff[DIGIT_W-1:0];
      end
      return d;
   endfunction

endpackage

// ----- sv/radix_number_parser_top.sv -----
// top level of the radix number parser: character stream in, parsed number out
//
// Usage: one ASCII character per req beat on req_tdata, req_tlast marks the
// final character of a string. Digits 0-9/a-f/A-F are accumulated as hex,
// decimal and octal at once; a leading "0x", any letter digit or an 'h' end
// selects hex, an 'o' end selects octal, otherwise decimal. The first other
// character ends the number and later characters are ignored.
// One rsp beat leaves per string, caused by the beat with req_tlast set; it
// carries the value (mod 2^32), a valid flag, the radix and an overflow flag.
// Path: an accepted character is held in the input register and parsed from there;
// a final one into the result register. Throughput: one character per cycle while
// no final character waits, set by the single accumulator stage (value*10 + digit
// as one add tree) between input and result registers.
// Stall: while rsp is held off the result register keeps its beat; characters
// that give no result keep flowing, a final character waits in the input
// register with req_tready low until the result register frees.
// Reset: synchronous, clears all parse state and both valid flags.
module radix_number_parser_top
   import rnp_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // input characters
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [CHAR_W-1:0] req_tdata,   // [7:0] ch
   input  logic             req_tlast,
   // parsed results
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata     // [31:0] value, [32] valid_res, [34:33] radix,
                                          // [35] overflow, [39:36] zero
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // input register
   logic              in_vld_ff, in_vld_in;
   logic [CHAR_W-1:0] in_ch_ff;
   logic              in_last_ff;

   // parse state
   logic [VALUE_W-1:0] acc_hex_ff, acc_hex_in;
   logic [VALUE_W-1:0] acc_dec_ff, acc_dec_in;
   logic [VALUE_W-1:0] acc_oct_ff, acc_oct_in;
   radix_type          mode_ff, mode_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               ended_ff, ended_in;
   logic               many_ff, many_in;

   // result register
   logic               out_vld_ff, out_vld_in;
   logic [RSP_W-1:0]   out_data_ff;

   // step values
   digit_type          dig;
   logic               proc_go;
   logic               take_prefix;
   logic [VALUE_W-1:0] nx_hex, nx_dec, nx_oct;
   radix_type          nx_mode;
   logic [CNT_W-1:0]   nx_cnt;
   logic [POS_W-1:0]   nx_pos;
   logic               nx_ended, nx_many;
   logic               res_valid;
   logic [VALUE_W-1:0] res_value;

   // handshake: a final character needs a free result register
   assign proc_go    = in_vld_ff && (!in_last_ff || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || proc_go;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !proc_go);
   assign out_vld_in = (proc_go && in_last_ff) || (out_vld_ff && !rsp_tready);

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // one character step
   always_comb begin
      dig         = decode_digit(in_ch_ff);
      take_prefix = (pos_ff == POS_W'(1)) && (in_ch_ff == CHAR_LX) &&
                    (cnt_ff == CNT_ONE) && (acc_hex_ff == '0);
      nx_hex   = acc_hex_ff;
      nx_dec   = acc_dec_ff;
      nx_oct   = acc_oct_ff;
      nx_mode  = mode_ff;
      nx_cnt   = cnt_ff;
      nx_ended = ended_ff;
      nx_many  = many_ff;
      nx_pos   = (pos_ff < POS_W'(2)) ? pos_ff + POS_W'(1) : pos_ff;
      if (ended_ff) begin
         nx_pos = pos_ff;
      end else if (take_prefix) begin
         nx_mode = RADIX_HEX;
         nx_cnt  = '0;
      end else if (dig.is_digit) begin
         nx_hex = {acc_hex_ff[VALUE_W-5:0], 4'd0} + VALUE_W'(dig.value);
         nx_dec = {acc_dec_ff[VALUE_W-4:0], 3'd0} + {acc_dec_ff[VALUE_W-2:0], 1'b0}
                  + VALUE_W'(dig.value);
         nx_oct = {acc_oct_ff[VALUE_W-4:0], 3'd0} + VALUE_W'(dig.value);
         if (dig.is_letter) begin
            nx_mode = RADIX_HEX;
         end
         if (cnt_ff >= CNT_MAX) begin
            nx_many = 1'b1;
         end else begin
            nx_cnt = cnt_ff + CNT_ONE;
         end
      end else begin
         if (in_ch_ff == CHAR_LH || in_ch_ff == CHAR_UH) begin
            nx_mode = RADIX_HEX;
         end else if (in_ch_ff == CHAR_LO || in_ch_ff == CHAR_UO) begin
            nx_mode = RADIX_OCT;
         end
         nx_ended = 1'b1;
      end
   end

   // result selection
   always_comb begin
      res_valid = (nx_cnt != '0);
      case (nx_mode)
         RADIX_HEX: res_value = nx_hex;
         RADIX_OCT: res_value = nx_oct;
         default:   res_value = nx_dec;
      endcase
      if (!res_valid) begin
         res_value = '0;
      end
   end

   // next parse state: back to reset values after a final character
   always_comb begin
      acc_hex_in = acc_hex_ff;
      acc_dec_in = acc_dec_ff;
      acc_oct_in = acc_oct_ff;
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      ended_in   = ended_ff;
      many_in    = many_ff;
      if (proc_go) begin
         if (in_last_ff) begin
            acc_hex_in = '0;
            acc_dec_in = '0;
            acc_oct_in = '0;
            mode_in    = RADIX_DEC;
            cnt_in     = '0;
            pos_in     = '0;
            ended_in   = 1'b0;
            many_in    = 1'b0;
         end else begin
            acc_hex_in = nx_hex;
            acc_dec_in = nx_dec;
            acc_oct_in = nx_oct;
            mode_in    = nx_mode;
            cnt_in     = nx_cnt;
            pos_in     = nx_pos;
            ended_in   = nx_ended;
            many_in    = nx_many;
         end
      end
   end

   // control and parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         acc_hex_ff <= '0;
         acc_dec_ff <= '0;
         acc_oct_ff <= '0;
         mode_ff    <= RADIX_DEC;
         cnt_ff     <= '0;
         pos_ff     <= '0;
         ended_ff   <= 1'b0;
         many_ff    <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         acc_hex_ff <= acc_hex_in;
         acc_dec_ff <= acc_dec_in;
         acc_oct_ff <= acc_oct_in;
         mode_ff    <= mode_in;
         cnt_ff     <= cnt_in;
         pos_ff     <= pos_in;
         ended_ff   <= ended_in;
         many_ff    <= many_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (proc_go && in_last_ff) begin
         out_data_ff <= {4'd0, nx_many, nx_mode, res_valid, res_value};
      end
   end

`ifndef SYNTHESIS
   // digit count never passes its limit
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("digit count above limit");

   // a final character leaves clean parse state behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      proc_go && in_last_ff |=> cnt_ff == '0 && !ended_ff && !many_ff && pos_ff == '0)
      else $error("parse state not cleared after final character");

   // a result without digits carries a zero value and no overflow
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_data_ff[32] |-> out_data_ff[31:0] == '0 && !out_data_ff[35])
      else $error("invalid result with nonzero value or overflow");

   // a held result is not overwritten by a new final character
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |-> !(proc_go && in_last_ff))
      else $error("result register overrun");
`endif

endmodule
